FILE: sv/slot_window_address_decoder_macros.svh
// ----------------------------------------------------------------------------
// Slot window address decoder assertion macros
// Shared property shorthands for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef SLOT_WINDOW_ADDRESS_DECODER_MACROS_SVH
`define SLOT_WINDOW_ADDRESS_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
// The using scope provides clk_i and rst_ni.
`define SWAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
// The using scope provides clk_i and rst_ni.
`define SWAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/swad_pkg.sv
// ----------------------------------------------------------------------------
// Slot window address decoder package
// Types, codes and constants shared by the decoder's modules.
// ----------------------------------------------------------------------------
package swad_pkg;

  localparam int unsigned SlotCountDefault = 32;
  localparam int unsigned MaxRangesDefault = 16;

  localparam int unsigned AddrW      = 32;
  localparam int unsigned OffsetW    = 25;
  localparam int unsigned SizeW      = 4;
  localparam int unsigned IdW        = 4;
  localparam int unsigned WinOffW    = 20;
  localparam int unsigned SlotFieldW = OffsetW - WinOffW;
  localparam int unsigned BaseW      = 12;
  localparam int unsigned HalfW      = 16;

  localparam logic [SizeW-1:0] CtrlSize = SizeW'(4);

  typedef enum logic [1:0] {
    OP_CTRL_WRITE = 2'd0,
    OP_WIN_READ   = 2'd1,
    OP_WIN_WRITE  = 2'd2,
    OP_REG_RANGE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_OVERLAP  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOK,
    BK_SCAN,
    BK_SHIFT,
    BK_WRITE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [OffsetW-1:0]   access_offset;
    logic [SizeW-1:0]     access_size;
    logic [AddrW-1:0]     write_data;
    logic [AddrW-1:0]     range_start;
    logic [AddrW-1:0]     range_size;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic                 hit;
    logic [IdW-1:0]       device_id;
    logic [AddrW-1:0]     device_offset;
    logic [AddrW-1:0]     global_address;
    logic                 read_as_zero;
  } out_t;

  typedef struct packed {
    opcode_e              op;
    status_e              status;
    logic [AddrW-1:0]     addr;
    logic [AddrW-1:0]     rstart;
    logic [AddrW-1:0]     rsize;
  } cmd_t;

  typedef struct packed {
    logic [AddrW-1:0]     start;
    logic [AddrW-1:0]     size;
    logic [IdW-1:0]       id;
  } entry_t;

endpackage

FILE: sv/swad_ram.sv
// ----------------------------------------------------------------------------
// Slot window address decoder RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swad_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/swad_front.sv
// ----------------------------------------------------------------------------
// Slot window address decoder front end
// Accepts items, owns the slot base registers and translates window offsets.
// ----------------------------------------------------------------------------
module swad_front #(
  parameter int unsigned SlotCount = swad_pkg::SlotCountDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swad_pkg::in_t    in_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output swad_pkg::cmd_t   cmd_o
);

  localparam int unsigned SlotIdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned PairW    = swad_pkg::OffsetW - 2;

  logic [swad_pkg::BaseW-1:0]      slot_base_q [SlotCount];
  logic [swad_pkg::BaseW-1:0]      slot_base_d [SlotCount];
  logic                            accept;
  logic                            ctrl_ok;
  logic [PairW-1:0]                pair;
  logic [swad_pkg::SlotFieldW-1:0] slot_field;
  logic                            slot_in_map;
  logic [swad_pkg::AddrW-1:0]      win_addr;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign ctrl_ok    = (in_data_i.opcode == swad_pkg::OP_CTRL_WRITE) &&
                      (in_data_i.access_size == swad_pkg::CtrlSize);
  assign pair       = in_data_i.access_offset[swad_pkg::OffsetW-1:2];
  assign slot_field = in_data_i.access_offset[swad_pkg::OffsetW-1:swad_pkg::WinOffW];
  assign slot_in_map = {1'b0, slot_field} < (swad_pkg::SlotFieldW + 1)'(SlotCount);

  always_comb begin
    for (int s = 0; s < SlotCount; s++) begin
      slot_base_d[s] = slot_base_q[s];
      if (accept && ctrl_ok && (pair == PairW'(s >> 1))) begin
        if (s[0]) begin
          slot_base_d[s] = in_data_i.write_data[swad_pkg::HalfW +: swad_pkg::BaseW];
        end else begin
          slot_base_d[s] = in_data_i.write_data[swad_pkg::BaseW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SlotCount; s++) begin
        slot_base_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < SlotCount; s++) begin
        slot_base_q[s] <= slot_base_d[s];
      end
    end
  end

  always_comb begin
    win_addr = '0;
    if (slot_in_map) begin
      win_addr = {slot_base_q[slot_field[SlotIdxW-1:0]],
                  in_data_i.access_offset[swad_pkg::WinOffW-1:0]};
    end
  end

  always_comb begin
    cmd_o.op     = in_data_i.opcode;
    cmd_o.status = swad_pkg::ST_OK;
    if ((in_data_i.opcode == swad_pkg::OP_CTRL_WRITE) && !ctrl_ok) begin
      cmd_o.status = swad_pkg::ST_BAD_SIZE;
    end
    cmd_o.addr   = win_addr;
    cmd_o.rstart = in_data_i.range_start;
    cmd_o.rsize  = in_data_i.range_size;
  end

endmodule

FILE: sv/swad_fifo.sv
// ----------------------------------------------------------------------------
// Slot window address decoder command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swad_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  swad_pkg::cmd_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  output swad_pkg::cmd_t  data_o,
  input  logic            pop_i
);

  swad_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic [1:0]     cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/swad_back.sv
// ----------------------------------------------------------------------------
// Slot window address decoder back end
// Walks the sorted range table for lookups and inserts, and holds the result.
// ----------------------------------------------------------------------------
module swad_back #(
  parameter int unsigned MaxRanges = swad_pkg::MaxRangesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  swad_pkg::cmd_t  q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output swad_pkg::out_t  out_data_o
);

  localparam int unsigned IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int unsigned CntW = $clog2(MaxRanges + 1);
  localparam int unsigned EntW = $bits(swad_pkg::entry_t);
  localparam int unsigned AW   = swad_pkg::AddrW;

  swad_pkg::back_state_e state_q, state_d;
  swad_pkg::cmd_t        cmd_q, cmd_d;
  swad_pkg::out_t        res_q, res_d;
  swad_pkg::out_t        out_q;
  logic                  out_valid_q, out_valid_d;
  logic                  load_out;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       pos_q, pos_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AW-1:0]         low_q, low_d;
  logic [AW-1:0]         high_q, high_d;
  logic [AW:0]           prev_end_q, prev_end_d;
  logic [AW:0]           nend_q, nend_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [EntW-1:0]       ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [EntW-1:0]       ram_rdata;
  swad_pkg::entry_t      ent;
  logic [AW:0]           ent_end;
  logic                  last_entry;
  logic                  table_full;
  logic [AW:0]           last_addr;
  logic [AW-1:0]         last_clamped;

  swad_ram #(
    .Width (EntW),
    .Depth (MaxRanges)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent          = swad_pkg::entry_t'(ram_rdata);
  assign ent_end      = {1'b0, ent.start} + {1'b0, ent.size};
  assign last_entry   = (CntW'(idx_q) + CntW'(1)) == count_q;
  assign table_full   = (count_q == CntW'(MaxRanges));
  assign last_addr    = nend_q - (AW + 1)'(1);
  assign last_clamped = last_addr[AW] ? '1 : last_addr[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swad_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    count_d    = count_q;
    low_d      = low_q;
    high_d     = high_q;
    prev_end_d = prev_end_q;
    nend_d     = nend_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = '0;
    ram_raddr  = idx_q;

    unique case (state_q)
      swad_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          cmd_d = q_data_i;
          res_d = '0;
          unique case (q_data_i.op)
            swad_pkg::OP_CTRL_WRITE: begin
              res_d.status = q_data_i.status;
              state_d      = swad_pkg::BK_EMIT;
            end
            swad_pkg::OP_WIN_READ, swad_pkg::OP_WIN_WRITE: begin
              res_d.global_address = q_data_i.addr;
              res_d.read_as_zero   = (q_data_i.op == swad_pkg::OP_WIN_READ);
              if ((q_data_i.addr >= low_q) && (q_data_i.addr <= high_q) &&
                  (count_q != '0)) begin
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = swad_pkg::BK_LOOK;
              end else begin
                state_d = swad_pkg::BK_EMIT;
              end
            end
            swad_pkg::OP_REG_RANGE: begin
              nend_d = {1'b0, q_data_i.rstart} + {1'b0, q_data_i.rsize};
              if (table_full) begin
                res_d.status = swad_pkg::ST_FULL;
                state_d      = swad_pkg::BK_EMIT;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = swad_pkg::BK_WRITE;
              end else begin
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = swad_pkg::BK_SCAN;
              end
            end
          endcase
        end
      end

      swad_pkg::BK_LOOK: begin
        ram_raddr = idx_q + IdxW'(1);
        if ((cmd_q.addr >= ent.start) && ({1'b0, cmd_q.addr} < ent_end)) begin
          res_d.hit           = 1'b1;
          res_d.device_id     = ent.id;
          res_d.device_offset = cmd_q.addr - ent.start;
          res_d.read_as_zero  = 1'b0;
          state_d             = swad_pkg::BK_EMIT;
        end else if (last_entry) begin
          state_d = swad_pkg::BK_EMIT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      swad_pkg::BK_SCAN: begin
        ram_raddr  = idx_q + IdxW'(1);
        prev_end_d = ent_end;
        if (ent.start > cmd_q.rstart) begin
          pos_d = idx_q;
          if (((idx_q != '0) && (prev_end_q > {1'b0, cmd_q.rstart})) ||
              (nend_q > {1'b0, ent.start})) begin
            res_d.status = swad_pkg::ST_OVERLAP;
            state_d      = swad_pkg::BK_EMIT;
          end else begin
            ram_raddr = IdxW'(count_q - CntW'(1));
            idx_d     = IdxW'(count_q - CntW'(1));
            state_d   = swad_pkg::BK_SHIFT;
          end
        end else if (last_entry) begin
          pos_d = IdxW'(count_q);
          if (ent_end > {1'b0, cmd_q.rstart}) begin
            res_d.status = swad_pkg::ST_OVERLAP;
            state_d      = swad_pkg::BK_EMIT;
          end else begin
            state_d = swad_pkg::BK_WRITE;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      swad_pkg::BK_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + IdxW'(1);
        ram_wdata = ram_rdata;
        if (idx_q == pos_q) begin
          state_d = swad_pkg::BK_WRITE;
        end else begin
          ram_raddr = idx_q - IdxW'(1);
          idx_d     = idx_q - IdxW'(1);
        end
      end

      swad_pkg::BK_WRITE: begin
        ram_we          = 1'b1;
        ram_waddr       = pos_q;
        ram_wdata       = {cmd_q.rstart, cmd_q.rsize, swad_pkg::IdW'(count_q)};
        count_d         = count_q + CntW'(1);
        res_d.status    = swad_pkg::ST_OK;
        res_d.device_id = swad_pkg::IdW'(count_q);
        if (cmd_q.rstart < low_q) begin
          low_d = cmd_q.rstart;
        end
        if ((cmd_q.rsize != '0) && (last_clamped > high_q)) begin
          high_d = last_clamped;
        end
        state_d = swad_pkg::BK_EMIT;
      end

      swad_pkg::BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = swad_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = swad_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      low_q       <= '1;
      high_q      <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    prev_end_q <= prev_end_d;
    nend_q     <= nend_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/slot_window_address_decoder.sv
// ----------------------------------------------------------------------------
// Slot window address decoder
// Translates slot window offsets to global addresses and matches them against
// a sorted table of device ranges; also programs slot bases and adds ranges.
// ----------------------------------------------------------------------------
// The back end takes one item at a time from the queue, walks the range
// table for a lookup inside the mapped bounds or for a range registration,
// and loads the result into the output register before it takes the next
// item; a two-entry queue and the output register let new items arrive
// while a result waits.
// Reset clears the slot bases, the range count and the mapped bounds at once.
module slot_window_address_decoder #(
  parameter int unsigned SlotCount = swad_pkg::SlotCountDefault,
  parameter int unsigned MaxRanges = swad_pkg::MaxRangesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  swad_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output swad_pkg::out_t  out_data_o
);

  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;
  swad_pkg::cmd_t q_wdata;
  swad_pkg::cmd_t q_rdata;

  swad_front #(
    .SlotCount (SlotCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (q_wdata)
  );

  swad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  swad_back #(
    .MaxRanges (MaxRanges)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/swad_checker.sv
// ----------------------------------------------------------------------------
// Slot window address decoder checker
// Port-level assertions on the decoder's channels, bound to the top.
// ----------------------------------------------------------------------------
`include "slot_window_address_decoder_macros.svh"

module swad_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input swad_pkg::in_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input swad_pkg::out_t  out_data_o
);

  logic in_stall;
  logic out_stall;
  logic out_hit;
  logic hit_ok;
  logic out_err;
  logic err_clean;
  logic out_miss;

  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_hit   = out_valid_o && out_data_o.hit;
  assign hit_ok    = !out_data_o.read_as_zero && (out_data_o.status == swad_pkg::ST_OK);
  assign out_err   = out_valid_o && (out_data_o.status != swad_pkg::ST_OK);
  assign err_clean = !out_data_o.hit && (out_data_o.device_id == '0) &&
                     (out_data_o.device_offset == '0) && (out_data_o.global_address == '0);
  assign out_miss  = out_valid_o && !out_data_o.hit && (out_data_o.status == swad_pkg::ST_OK);

  `SWAD_ASSERT_NEXT(a_in_hold, in_stall, in_valid_i && $stable(in_data_i), "Input not held.")
  `SWAD_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_data_o), "Result not held.")
  `SWAD_ASSERT_NOW(a_hit_not_zero, out_hit, hit_ok, "Hit result flagged read as zero or error.")
  `SWAD_ASSERT_NOW(a_error_clean, out_err, err_clean, "Error result carries payload.")
  `SWAD_ASSERT_NOW(a_miss_offset, out_miss, out_data_o.device_offset == '0, "Miss has an offset.")

endmodule

bind slot_window_address_decoder swad_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: dv/swad_tb_pkg.sv
// ----------------------------------------------------------------------------
// Slot window address decoder scoreboard
// Tracks slot bases and the sorted device range table as transfers are
// accepted, predicts the response to each request and checks every response
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
package swad_tb_pkg;

  import swad_pkg::*;

  localparam int unsigned NumSlots    = SlotCountDefault;
  localparam int unsigned NumRanges   = MaxRangesDefault;
  localparam int unsigned ReportLimit = 10;

  class decoder_scoreboard;

    logic [BaseW-1:0] slot_base [NumSlots];
    logic [AddrW-1:0] map_start [NumRanges];
    logic [AddrW-1:0] map_size  [NumRanges];
    logic [IdW-1:0]   map_id    [NumRanges];
    int unsigned      map_count;
    logic [AddrW-1:0] low_bound;
    logic [AddrW-1:0] high_bound;
    out_t             pending_responses [$];
    int unsigned      failures;

    function new();
      foreach (slot_base[i]) slot_base[i] = '0;
      foreach (map_start[i]) begin
        map_start[i] = '0;
        map_size[i]  = '0;
        map_id[i]    = '0;
      end
      map_count  = 0;
      low_bound  = '1;
      high_bound = '0;
      failures   = 0;
    endfunction

    function logic [AddrW:0] entry_end(int unsigned i);
      return {1'b0, map_start[i]} + {1'b0, map_size[i]};
    endfunction

    function out_t decode_item(in_t req);
      out_t             rsp;
      logic [AddrW-1:0] addr;
      logic [AddrW:0]   new_end;
      logic [AddrW:0]   last;
      int unsigned      idx;
      int unsigned      pos;
      int unsigned      i;
      logic             fits;
      rsp        = '0;
      rsp.status = ST_OK;
      case (req.opcode)
        OP_CTRL_WRITE: begin
          if (req.access_size != CtrlSize) begin
            rsp.status = ST_BAD_SIZE;
          end else begin
            idx = 2 * (req.access_offset >> 2);
            if (idx < NumSlots) slot_base[idx] = req.write_data[BaseW-1:0];
            if (idx + 1 < NumSlots) slot_base[idx+1] = req.write_data[HalfW +: BaseW];
          end
        end
        OP_WIN_READ, OP_WIN_WRITE: begin
          idx  = req.access_offset[OffsetW-1:WinOffW];
          addr = '0;
          if (idx < NumSlots) addr = {slot_base[idx], req.access_offset[WinOffW-1:0]};
          if (addr >= low_bound && addr <= high_bound) begin
            for (i = 0; i < map_count; i++) begin
              if (!rsp.hit && addr >= map_start[i] && {1'b0, addr} < entry_end(i)) begin
                rsp.hit           = 1'b1;
                rsp.device_id     = map_id[i];
                rsp.device_offset = addr - map_start[i];
              end
            end
          end
          rsp.global_address = addr;
          rsp.read_as_zero   = (req.opcode == OP_WIN_READ) && !rsp.hit;
        end
        default: begin
          if (map_count >= NumRanges) begin
            rsp.status = ST_FULL;
          end else begin
            new_end = {1'b0, req.range_start} + {1'b0, req.range_size};
            pos     = 0;
            while (pos < map_count && map_start[pos] <= req.range_start) pos++;
            fits = 1'b1;
            if (pos > 0 && entry_end(pos - 1) > {1'b0, req.range_start}) fits = 1'b0;
            if (pos < map_count && new_end > {1'b0, map_start[pos]}) fits = 1'b0;
            if (!fits) begin
              rsp.status = ST_OVERLAP;
            end else begin
              for (i = map_count; i > pos; i--) begin
                map_start[i] = map_start[i-1];
                map_size[i]  = map_size[i-1];
                map_id[i]    = map_id[i-1];
              end
              map_start[pos] = req.range_start;
              map_size[pos]  = req.range_size;
              map_id[pos]    = IdW'(map_count);
              rsp.device_id  = IdW'(map_count);
              map_count++;
              if (req.range_start < low_bound) low_bound = req.range_start;
              if (req.range_size != '0) begin
                last = new_end - 1;
                if (last[AddrW]) last = {1'b0, {AddrW{1'b1}}};
                if (last[AddrW-1:0] > high_bound) high_bound = last[AddrW-1:0];
              end
            end
          end
        end
      endcase
      return rsp;
    endfunction

    function void note_request(in_t req);
      pending_responses.push_back(decode_item(req));
    endfunction

    function string describe(out_t r);
      return $sformatf("status=%0d hit=%0b id=%0d dev_off=%h addr=%h raz=%0b",
                       r.status, r.hit, r.device_id, r.device_offset,
                       r.global_address, r.read_as_zero);
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (pending_responses.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected response transfer: %s", describe(got));
        end
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status || got.hit !== want.hit ||
          got.device_id !== want.device_id || got.device_offset !== want.device_offset ||
          got.global_address !== want.global_address ||
          got.read_as_zero !== want.read_as_zero) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("response mismatch: expected %s", describe(want));
          $display("                   actual   %s", describe(got));
        end
      end
    endfunction

  endclass

endpackage

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Slot window address decoder testbench
// Drives directed and random requests through the valid/ready input with
// random gaps, stalls the response side at random and twice for a long
// stretch, and checks every response transfer against a scoreboard that
// models the slot bases and the sorted range table.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import swad_pkg::*;
  import swad_tb_pkg::*;

  localparam int unsigned RandomItems   = 1530;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 100;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  decoder_scoreboard sb;
  int unsigned       cycle_count  = 0;
  bit                hold_off_req = 1'b0;
  bit                send_calm    = 1'b0;

  always #6 clk_i = ~clk_i;

  slot_window_address_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("slot_window_address_decoder regression: fail");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [BaseW-1:0] pick_base();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hfff;
      2: return 12'habc;
      3: return 12'h123;
      4: return 12'h800;
      5: return 12'h7ff;
      6: return 12'h001;
      default: return 12'h555;
    endcase
  endfunction

  function automatic in_t make_item(opcode_e op, logic [OffsetW-1:0] offset,
                                    logic [SizeW-1:0] size, logic [AddrW-1:0] data,
                                    logic [AddrW-1:0] start, logic [AddrW-1:0] length);
    in_t it;
    it.opcode        = op;
    it.access_offset = offset;
    it.access_size   = size;
    it.write_data    = data;
    it.range_start   = start;
    it.range_size    = length;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t              it;
    int unsigned      r;
    int unsigned      k;
    int unsigned      s;
    int unsigned      slot;
    int unsigned      rot;
    logic [AddrW-1:0] target;
    logic             found;
    it.opcode        = opcode_e'($urandom_range(0, 3));
    it.access_offset = OffsetW'($urandom);
    it.access_size   = SizeW'($urandom);
    it.write_data    = $urandom;
    it.range_start   = $urandom;
    it.range_size    = $urandom;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.opcode = OP_CTRL_WRITE;
      if ($urandom_range(0, 9) != 0) begin
        it.access_size   = CtrlSize;
        it.access_offset = OffsetW'($urandom_range(0, 63));
        it.write_data    = {4'($urandom), pick_base(), 4'($urandom), pick_base()};
      end
    end else if (r < 20) begin
      it.opcode = OP_REG_RANGE;
      k = $urandom_range(0, 9);
      if (k < 6) begin
        it.range_start = {pick_base(), 20'($urandom)};
        it.range_size  = AddrW'($urandom_range(1, 'h4000));
      end else if (k < 8 && sb.map_count != 0) begin
        s = $urandom_range(0, sb.map_count - 1);
        it.range_start = sb.map_start[s] + sb.map_size[s];
        it.range_size  = AddrW'($urandom_range(0, 'h800));
      end else if (k == 8) begin
        it.range_start = {pick_base(), 20'($urandom)};
        it.range_size  = '0;
      end
    end else begin
      it.opcode = $urandom_range(0, 1) ? OP_WIN_READ : OP_WIN_WRITE;
      if ($urandom_range(0, 9) < 7 && sb.map_count != 0) begin
        s = $urandom_range(0, sb.map_count - 1);
        case ($urandom_range(0, 3))
          0: target = sb.map_start[s];
          1: target = sb.map_start[s] + sb.map_size[s] - 1;
          2: target = sb.map_start[s] + sb.map_size[s];
          default: target = sb.map_start[s] + $urandom_range(0, sb.map_size[s]);
        endcase
        found = 1'b0;
        rot   = $urandom_range(0, NumSlots - 1);
        for (k = 0; k < NumSlots; k++) begin
          slot = (k + rot) % NumSlots;
          if (!found && sb.slot_base[slot] == target[AddrW-1:WinOffW]) begin
            found            = 1'b1;
            it.access_offset = {SlotFieldW'(slot), target[WinOffW-1:0]};
          end
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = send_calm ? 0 : draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin : response_side
    int unsigned n;
    bit          calm;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        n = calm ? 0 : draw_gap();
        if (n != 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin : request_side
    int unsigned n;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(OP_WIN_READ, '0, '0, '0, '0, '0));
    send_item(make_item(OP_WIN_WRITE, '1, '1, '1, '1, '1));
    send_item(make_item(OP_CTRL_WRITE, '0, 4'd0, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, '0, 4'd8, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, '0, 4'd15, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, '0, 4'd3, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, '0, CtrlSize, 32'h0fff_fabc, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, 25'd64, CtrlSize, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, '1, CtrlSize, 32'hffff_ffff, '0, '0));
    send_item(make_item(OP_CTRL_WRITE, 25'd7, CtrlSize, 32'h0001_0000, '0, '0));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'habc0_0000, 32'h0000_1000));
    send_item(make_item(OP_WIN_READ, 25'h000_0010, '0, '0, '0, '0));
    send_item(make_item(OP_WIN_READ, 25'h000_0fff, '0, '0, '0, '0));
    send_item(make_item(OP_WIN_READ, 25'h000_1000, '0, '0, '0, '0));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'habc0_0800, 32'h0000_0010));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'habb0_0000, 32'h0010_0001));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'hffff_ff00, 32'hffff_ffff));
    send_item(make_item(OP_WIN_WRITE, {5'd1, 20'hfffff}, '0, '0, '0, '0));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'h0000_0100, 32'h0000_0000));
    send_item(make_item(OP_REG_RANGE, '0, '0, '0, 32'h0000_0000, 32'h0000_0100));
    send_item(make_item(OP_WIN_READ, {5'd2, 20'h00000}, '0, '0, '0, '0));
    send_item(make_item(OP_WIN_READ, {5'd2, 20'h00100}, '0, '0, '0, '0));
    send_item(make_item(OP_WIN_WRITE, {5'd3, 20'h00000}, '0, '0, '0, '0));

    for (n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 49) == 0) send_calm = ~send_calm;
      if (n == 300 || n == 1000) hold_off_req = 1'b1;
      send_item(random_item());
    end
    in_valid_i <= 1'b0;

    while (sb.pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_responses.size() == 0) begin
      $display("slot_window_address_decoder regression: pass");
    end else begin
      $display("slot_window_address_decoder regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/swad_pkg.sv
sv/swad_ram.sv
sv/swad_front.sv
sv/swad_fifo.sv
sv/swad_back.sv
sv/slot_window_address_decoder.sv
sv/swad_checker.sv
dv/swad_tb_pkg.sv
dv/tb_top.sv
